/* design/cgf_pkg.sv */
// Shared types and constants of the 3x3 grey filter.
package cgf_pkg;

  localparam int PIX_W   = 8;
  localparam int SIZE_W  = 11;
  localparam int WT_W    = 6;
  localparam int TAPS    = 9;
  localparam int KERN_W  = WT_W * TAPS;
  localparam int SCALE_W = 16;
  localparam int SUM_W   = 18;
  localparam int PROD_W  = SUM_W + SCALE_W;
  localparam int TAP_W   = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [SIZE_W-1:0]  ROW_LENGTH_RST = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0]  FRAME_ROWS_RST = SIZE_W'(1024);
  localparam logic [KERN_W-1:0]  KERNEL_RST     = KERN_W'(64'd290342004330625);
  localparam logic [SCALE_W-1:0] SCALE_RST      = SCALE_W'(4096);

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NORM_SCALE = 2'd3;

  localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(TAPS - 1);

  typedef struct packed {
    logic accept;
    logic update;
    logic mac_step;
    logic scale;
    logic emit;
  } cgf_cmd_t;

  typedef struct packed {
    logic produce;
    logic last_tap;
    logic out_free;
  } cgf_status_t;

endpackage

/* design/conv3x3_grey_filter_top.sv */
// Top level of the 3x3 weighted-sum grey filter: controller plus datapath.
//
//   channel | ports                                   | beat
//   --------+-----------------------------------------+---------------------------
//   input   | in_valid, in_ready, in_pixel_in         | one bordered-frame pixel
//   output  | out_valid, out_ready, out_pixel_out,    | one filtered interior pixel
//           | out_frame_end                           |
//   config  | cfg_wr_en, cfg_index, cfg_wdata         | one register write
//
// A border pixel is accepted with a line store read, then updated.
// An interior-producing pixel is accepted and updated, then accumulated on
// the single shared multiply-accumulate unit (one weight per cycle, nine
// weights), then scaled by the scale multiply and loaded into the output register.
// The output register lets the next beat be accepted while a result waits;
// the block stalls only when it needs to load a result into a full register.
// Reset is synchronous and active low; it clears the column and row counters, window, control
// and configuration, while the line stores stay undefined until written.
module conv3x3_grey_filter_top
  import cgf_pkg::*;
#(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KERN_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     in_pixel_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIX_W-1:0]     out_pixel_out,
  output logic                 out_frame_end
);

  cgf_cmd_t    cmd;
  cgf_status_t status;

  // The controller walks each beat through accept and update and, for interior pixels, accumulate, scale and emit.
  cgf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the line stores, the 3x3 window and the arithmetic.
  cgf_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_pixel_in   (in_pixel_in),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out),
    .out_frame_end (out_frame_end)
  );

endmodule

/* design/cgf_ctrl.sv */
// Controller state machine that sequences one pixel through the datapath.
module cgf_ctrl
  import cgf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  cgf_status_t status,
  output cgf_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_MAC,
    S_SCALE,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = status.produce ? S_MAC : S_IDLE;
      end
      S_MAC: begin
        cmd.mac_step = 1'b1;
        if (status.last_tap) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = status.out_free;
        if (status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/cgf_datapath.sv */
// Datapath: configuration registers, line stores, window, counters, MAC and output stage.
module cgf_datapath
  import cgf_pkg::*;
#(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KERN_W-1:0]    cfg_wdata,
  input  logic [PIX_W-1:0]     in_pixel_in,
  input  cgf_cmd_t             cmd,
  output cgf_status_t          status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIX_W-1:0]     out_pixel_out,
  output logic                 out_frame_end
);

  localparam int DEPTH = MAX_COLS + 2;
  localparam int CW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_ROWS + 2);

  logic [SIZE_W-1:0]  row_length_r;
  logic [SIZE_W-1:0]  frame_rows_r;
  logic [KERN_W-1:0]  kernel_r;
  logic [SCALE_W-1:0] scale_r;

  logic [PIX_W-1:0] upper_mem [DEPTH];
  logic [PIX_W-1:0] lower_mem [DEPTH];
  logic [PIX_W-1:0] top_r, mid_r, pix_r;
  logic [PIX_W-1:0] win_r [TAPS];

  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [CW-1:0] last_col;
  logic [RW-1:0] last_row;

  logic [TAP_W-1:0]     tap_r;
  logic [SUM_W-1:0]     acc_r;
  logic [PROD_W-1:0]    prod_r;
  logic                 fe_r;
  logic                 out_valid_r;
  logic [PIX_W-1:0]     out_pix_r;
  logic                 out_fe_r;
  logic [WT_W-1:0]      tap_wt;
  logic [WT_W+PIX_W-1:0] tap_prod;

  // Sizes out of range are clamped: zero acts as one, large values as the maximum.
  always_comb begin
    if (row_length_r == '0) begin
      last_col = CW'(2);
    end else if (32'(row_length_r) > 32'(MAX_COLS)) begin
      last_col = CW'(MAX_COLS + 1);
    end else begin
      last_col = CW'(row_length_r) + CW'(1);
    end
    if (frame_rows_r == '0) begin
      last_row = RW'(2);
    end else if (32'(frame_rows_r) > 32'(MAX_ROWS)) begin
      last_row = RW'(MAX_ROWS + 1);
    end else begin
      last_row = RW'(frame_rows_r) + RW'(1);
    end
  end

  assign status.produce  = (32'(row_r) >= 32'd2) && (32'(col_r) >= 32'd2);
  assign status.last_tap = (tap_r == LAST_TAP);
  assign status.out_free = !out_valid_r || out_ready;

  assign tap_wt   = kernel_r[WT_W*tap_r +: WT_W];
  assign tap_prod = tap_wt * win_r[tap_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= ROW_LENGTH_RST;
      frame_rows_r <= FRAME_ROWS_RST;
      kernel_r     <= KERNEL_RST;
      scale_r      <= SCALE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ROW_LENGTH: row_length_r <= cfg_wdata[SIZE_W-1:0];
        CFG_FRAME_ROWS: frame_rows_r <= cfg_wdata[SIZE_W-1:0];
        CFG_KERNEL:     kernel_r     <= cfg_wdata;
        CFG_NORM_SCALE: scale_r      <= cfg_wdata[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Line stores: read at accept, written back in the following cycle at the same column.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_r <= in_pixel_in;
      top_r <= upper_mem[col_r];
      mid_r <= lower_mem[col_r];
    end
    if (cmd.update) begin
      upper_mem[col_r] <= mid_r;
      lower_mem[col_r] <= pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      for (int i = 0; i < TAPS; i++) begin
        win_r[i] <= '0;
      end
    end else if (cmd.update) begin
      for (int m = 0; m < 3; m++) begin
        win_r[m*3]   <= win_r[m*3+1];
        win_r[m*3+1] <= win_r[m*3+2];
      end
      win_r[2] <= top_r;
      win_r[5] <= mid_r;
      win_r[8] <= pix_r;
      if (col_r >= last_col) begin
        col_r <= '0;
        row_r <= (row_r >= last_row) ? '0 : row_r + RW'(1);
      end else begin
        col_r <= col_r + CW'(1);
        if (row_r > last_row) begin
          row_r <= last_row;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      fe_r  <= (row_r >= last_row) && (col_r >= last_col);
      acc_r <= '0;
      tap_r <= '0;
    end
    if (cmd.mac_step) begin
      acc_r <= acc_r + SUM_W'(tap_prod);
      tap_r <= tap_r + TAP_W'(1);
    end
    if (cmd.scale) begin
      prod_r <= PROD_W'(acc_r) * PROD_W'(scale_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_pix_r <= (|prod_r[PROD_W-1:SCALE_W+PIX_W]) ? '1 : prod_r[SCALE_W +: PIX_W];
      out_fe_r  <= fe_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pix_r;
  assign out_frame_end = out_fe_r;

endmodule
